@@ rtl/bafc_pkg.sv @@
// shared constants for the byte alu core: operation codes, status bit
// positions and the beat fields of both stream channels
// no dependencies
package bafc_pkg;

    localparam int FuncW   = 4;
    localparam int ByteW   = 8;

    // stream beat widths, padded to whole bytes
    localparam int InDataW  = 40;
    localparam int OutDataW = 32;

    // operation codes
    localparam logic [FuncW-1:0] FuncAdd = 4'd0;
    localparam logic [FuncW-1:0] FuncSub = 4'd1;
    localparam logic [FuncW-1:0] FuncAnd = 4'd2;
    localparam logic [FuncW-1:0] FuncOr  = 4'd3;
    localparam logic [FuncW-1:0] FuncXor = 4'd4;
    localparam logic [FuncW-1:0] FuncCmp = 4'd5;
    localparam logic [FuncW-1:0] FuncAsl = 4'd6;
    localparam logic [FuncW-1:0] FuncLsr = 4'd7;
    localparam logic [FuncW-1:0] FuncRol = 4'd8;
    localparam logic [FuncW-1:0] FuncRor = 4'd9;

    // status byte bit positions
    localparam int FlCarry = 0;
    localparam int FlZero  = 1;
    localparam int FlDec   = 3;
    localparam int FlOvf   = 6;
    localparam int FlSign  = 7;

    typedef struct packed {
        logic [FuncW-1:0] func;
        logic [ByteW-1:0] acc_in;
        logic [ByteW-1:0] operand;
        logic [ByteW-1:0] compare_left;
        logic [ByteW-1:0] flags_in;
    } op_t;

    typedef struct packed {
        logic             extra_cycle;
        logic [ByteW-1:0] flags_out;
        logic [ByteW-1:0] shift_out;
        logic [ByteW-1:0] acc_out;
    } res_t;

endpackage

@@ rtl/byte_alu_with_bcd_and_flags_core.sv @@
// 8-bit alu with binary and bcd add/subtract, logic ops, compare and shifts
// two-stage stream pipeline: operand register, single-pass alu, result register
// depends on bafc_pkg
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+---------------------------------------
//  s       | in  | s_tvalid / s_tready      | s_tdata: func, acc_in, operand,
//          |     |                          |   compare_left, flags_in
//  m       | out | m_tvalid / m_tready      | m_tdata: acc_out, shift_out,
//          |     |                          |   flags_out, extra_cycle
//  cfg     | in  | cfg_valid / cfg_ready    | cfg_data: decimal_flags_enable
//
// one beat per cycle sustained while m_tready holds; each beat passes through
// the operand register and then the result register around the alu logic
// reset clears both stage valid bits and the decimal flags enable
// a stall on m backs up through the two stages; s_tready drops only when both hold beats
module byte_alu_with_bcd_and_flags_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [3:0] func, [11:4] acc_in, [19:12] operand, [27:20] compare_left,
    // [35:28] flags_in, [39:36] zero
    input  logic [bafc_pkg::InDataW-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] acc_out, [15:8] shift_out, [23:16] flags_out, [24] extra_cycle,
    // [31:25] zero
    output logic [bafc_pkg::OutDataW-1:0]  m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data
);

    bafc_pkg::op_t  op_reg;
    logic           op_valid_reg;
    bafc_pkg::res_t res_reg;
    bafc_pkg::res_t res_next;
    logic           res_valid_reg;
    logic           dec_flags_en_reg;
    logic           op_advance;
    logic           s_accept;

    // alu intermediate values
    logic [7:0] a, b, f;
    logic       c;
    logic [7:0] bin_sum;
    logic [8:0] bin_sum_full;
    logic [7:0] bin_diff;
    logic       bin_ovf_add, bin_ovf_sub;
    logic [5:0] dlo_add, dhi_add;
    logic [7:0] dlo_sub, dhi_sub;
    logic [7:0] cmp_diff;
    logic [7:0] shifted;

    assign cfg_ready  = 1'b1;
    assign op_advance = !res_valid_reg || m_tready;
    assign s_tready   = !op_valid_reg || op_advance;
    assign s_accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_flags_en_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            dec_flags_en_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                op_valid_reg <= s_tvalid;
            end
            if (op_advance)
            begin
                res_valid_reg <= op_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_reg.func         <= s_tdata[3:0];
            op_reg.acc_in       <= s_tdata[11:4];
            op_reg.operand      <= s_tdata[19:12];
            op_reg.compare_left <= s_tdata[27:20];
            op_reg.flags_in     <= s_tdata[35:28];
        end
        if (op_advance && op_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    always_comb
    begin
        a = op_reg.acc_in;
        b = op_reg.operand;
        c = op_reg.flags_in[bafc_pkg::FlCarry];
        f = op_reg.flags_in;

        bin_sum_full = {1'b0, a} + {1'b0, b} + {8'd0, c};
        bin_sum      = bin_sum_full[7:0];
        bin_diff     = a - b - {7'd0, !c};
        bin_ovf_add  = ~(a[7] ^ b[7]) & (bin_sum[7] ^ b[7]);
        bin_ovf_sub  = (a[7] ^ b[7]) & (a[7] ^ bin_diff[7]);

        // bcd add: low digit corrected first, its carry feeds the high digit
        dlo_add = {2'b00, a[3:0]} + {2'b00, b[3:0]} + {5'd0, c};
        if (dlo_add > 6'd9)
        begin
            dlo_add = dlo_add + 6'd6;
        end
        dhi_add = {2'b00, a[7:4]} + {2'b00, b[7:4]} + {5'd0, (dlo_add > 6'd15)};

        // bcd subtract in byte-wide arithmetic, borrow seen on bit 4
        dlo_sub = {4'd0, a[3:0]} - {4'd0, b[3:0]} - {7'd0, !c};
        if (dlo_sub[4])
        begin
            dlo_sub = dlo_sub - 8'd6;
        end
        dhi_sub = {4'd0, a[7:4]} - {4'd0, b[7:4]} - {7'd0, dlo_sub[4]};
        if (dhi_sub[4])
        begin
            dhi_sub = dhi_sub - 8'd6;
        end

        cmp_diff = op_reg.compare_left - b;

        case (op_reg.func)
            bafc_pkg::FuncAsl: shifted = {b[6:0], 1'b0};
            bafc_pkg::FuncRol: shifted = {b[6:0], c};
            bafc_pkg::FuncLsr: shifted = {1'b0, b[7:1]};
            bafc_pkg::FuncRor: shifted = {c, b[7:1]};
            default:           shifted = 8'd0;
        endcase

        res_next.acc_out     = a;
        res_next.shift_out   = 8'd0;
        res_next.flags_out   = f;
        res_next.extra_cycle = 1'b0;

        case (op_reg.func)
            bafc_pkg::FuncAdd:
            begin
                if (f[bafc_pkg::FlDec])
                begin
                    res_next.extra_cycle = 1'b1;
                    if (dec_flags_en_reg)
                    begin
                        res_next.flags_out[bafc_pkg::FlZero] = (bin_sum == 8'd0);
                        res_next.flags_out[bafc_pkg::FlSign] = dhi_add[3];
                        res_next.flags_out[bafc_pkg::FlOvf]  = bin_ovf_add;
                    end
                    // high digit correction after the sign tap
                    if (dhi_add > 6'd9)
                    begin
                        dhi_add = dhi_add + 6'd6;
                    end
                    res_next.flags_out[bafc_pkg::FlCarry] = (dhi_add > 6'd15);
                    res_next.acc_out = {dhi_add[3:0], dlo_add[3:0]};
                end
                else
                begin
                    res_next.acc_out = bin_sum;
                    res_next.flags_out[bafc_pkg::FlCarry] = bin_sum_full[8];
                    res_next.flags_out[bafc_pkg::FlOvf]   = bin_ovf_add;
                    res_next.flags_out[bafc_pkg::FlZero]  = (bin_sum == 8'd0);
                    res_next.flags_out[bafc_pkg::FlSign]  = bin_sum[7];
                end
            end
            bafc_pkg::FuncSub:
            begin
                if (f[bafc_pkg::FlDec])
                begin
                    res_next.extra_cycle = 1'b1;
                    res_next.flags_out[bafc_pkg::FlCarry] = (dhi_sub[7:4] == 4'd0);
                    if (dec_flags_en_reg)
                    begin
                        res_next.flags_out[bafc_pkg::FlZero] = (bin_diff == 8'd0);
                        res_next.flags_out[bafc_pkg::FlSign] = dhi_sub[3];
                        res_next.flags_out[bafc_pkg::FlOvf]  = bin_ovf_sub;
                    end
                    res_next.acc_out = {dhi_sub[3:0], dlo_sub[3:0]};
                end
                else
                begin
                    res_next.acc_out = bin_diff;
                    res_next.flags_out[bafc_pkg::FlCarry] =
                        ({1'b0, a} >= ({1'b0, b} + {8'd0, !c}));
                    res_next.flags_out[bafc_pkg::FlOvf]   = bin_ovf_sub;
                    res_next.flags_out[bafc_pkg::FlZero]  = (bin_diff == 8'd0);
                    res_next.flags_out[bafc_pkg::FlSign]  = bin_diff[7];
                end
            end
            bafc_pkg::FuncAnd, bafc_pkg::FuncOr, bafc_pkg::FuncXor:
            begin
                if (op_reg.func == bafc_pkg::FuncAnd)
                begin
                    res_next.acc_out = a & b;
                end
                else if (op_reg.func == bafc_pkg::FuncOr)
                begin
                    res_next.acc_out = a | b;
                end
                else
                begin
                    res_next.acc_out = a ^ b;
                end
                res_next.flags_out[bafc_pkg::FlZero] = (res_next.acc_out == 8'd0);
                res_next.flags_out[bafc_pkg::FlSign] = res_next.acc_out[7];
            end
            bafc_pkg::FuncCmp:
            begin
                res_next.flags_out[bafc_pkg::FlCarry] = (op_reg.compare_left >= b);
                res_next.flags_out[bafc_pkg::FlZero]  = (cmp_diff == 8'd0);
                res_next.flags_out[bafc_pkg::FlSign]  = cmp_diff[7];
            end
            bafc_pkg::FuncAsl, bafc_pkg::FuncRol, bafc_pkg::FuncLsr, bafc_pkg::FuncRor:
            begin
                res_next.shift_out = shifted;
                // bit shifted out lands in carry
                if (op_reg.func == bafc_pkg::FuncAsl || op_reg.func == bafc_pkg::FuncRol)
                begin
                    res_next.flags_out[bafc_pkg::FlCarry] = b[7];
                end
                else
                begin
                    res_next.flags_out[bafc_pkg::FlCarry] = b[0];
                end
                res_next.flags_out[bafc_pkg::FlZero] = (shifted == 8'd0);
                res_next.flags_out[bafc_pkg::FlSign] = shifted[7];
            end
            default:
            begin
                res_next.acc_out = a;
            end
        endcase
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {7'd0, res_reg.extra_cycle, res_reg.flags_out,
                       res_reg.shift_out, res_reg.acc_out};

    // only add and subtract may report the extra decimal cycle
    a_extra_only_arith: assert property (@(posedge clk) disable iff (!rst_n)
        (op_valid_reg && op_advance && op_reg.func != bafc_pkg::FuncAdd
            && op_reg.func != bafc_pkg::FuncSub)
        |=> !res_reg.extra_cycle)
        else $error("extra cycle flagged for a non-arithmetic beat");

    // undefined codes pass accumulator and status through untouched
    a_undef_passthru: assert property (@(posedge clk) disable iff (!rst_n)
        (op_valid_reg && op_advance && op_reg.func > bafc_pkg::FuncRor)
        |=> (res_reg.acc_out == $past(op_reg.acc_in)
            && res_reg.flags_out == $past(op_reg.flags_in)
            && res_reg.shift_out == 8'd0))
        else $error("undefined operation changed the result");

    // input backpressure only when both stages are occupied
    a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (op_valid_reg && res_valid_reg && !m_tready))
        else $error("input stalled with room in the pipeline");

endmodule
